@@ hdl/tsp_pkg.sv @@
// Shared types and constants of the sampling task profiler.
`timescale 1ns / 1ps
`default_nettype none
package tsp_pkg;

    localparam int TID_W   = 16;
    localparam int HITS_W  = 32;
    localparam int CNT_W   = 32;
    localparam int PCT_W   = 10;
    localparam int CORE_W  = 4;
    localparam int DIV_W   = 40;
    localparam int DIVC_W  = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 128;
    localparam logic [6:0] PCT_SCALE = 7'd100;
    localparam logic [PCT_W-1:0] PCT_MAX = 10'd1023;
    localparam logic [CORE_W-1:0] CORE_RESET = 4'd2;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [HITS_W-1:0] hits;
        logic              done;
    } t_cell;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PCDIV,
        ST_SCAN,
        ST_PICK,
        ST_PCTDIV,
        ST_EMIT,
        ST_SUM
    } t_state;

endpackage
`default_nettype wire

@@ hdl/tsp_cell.sv @@
// One table cell holding a task, its hit counter and a dump mark.
`timescale 1ns / 1ps
`default_nettype none
module tsp_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_shift,
    input  tsp_pkg::t_cell               i_shift_in,
    input  wire                          i_wr,
    input  wire                          i_inc,
    input  wire [tsp_pkg::TID_W-1:0]     i_tid,
    input  wire                          i_clr_done,
    input  wire                          i_set_done,
    output tsp_pkg::t_cell               o_cell,
    output logic                         o_match
);

    logic [tsp_pkg::TID_W-1:0]  r_tid;
    logic [tsp_pkg::HITS_W-1:0] r_hits;
    logic                       r_done;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tid  <= i_shift_in.tid;
            r_hits <= i_shift_in.hits;
        end else if (i_wr) begin
            r_tid  <= i_tid;
            r_hits <= tsp_pkg::HITS_W'(1);
        end else if (i_inc) begin
            r_hits <= r_hits + tsp_pkg::HITS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_shift) begin
            r_done <= i_shift_in.done;
        end else if (i_clr_done || i_wr) begin
            r_done <= 1'b0;
        end else if (i_set_done) begin
            r_done <= 1'b1;
        end
    end

    assign o_cell  = '{tid: r_tid, hits: r_hits, done: r_done};
    assign o_match = (r_tid == i_tid);

endmodule
`default_nettype wire

@@ hdl/tsp_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tsp_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [tsp_pkg::DIV_W-1:0]   i_dividend,
    input  wire [tsp_pkg::DIV_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [tsp_pkg::DIV_W-1:0]  o_quotient
);

    logic [tsp_pkg::DIV_W-1:0]  r_rem;
    logic [tsp_pkg::DIV_W-1:0]  r_quo;
    logic [tsp_pkg::DIV_W-1:0]  r_div;
    logic [tsp_pkg::DIVC_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [tsp_pkg::DIV_W:0]    w_trial;
    logic                       w_ge;
    logic [tsp_pkg::DIV_W:0]    w_diff;

    assign w_trial = {r_rem, r_quo[tsp_pkg::DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[tsp_pkg::DIV_W-1:0] : w_trial[tsp_pkg::DIV_W-1:0];
            r_quo <= {r_quo[tsp_pkg::DIV_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tsp_pkg::DIVC_W'(tsp_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - tsp_pkg::DIVC_W'(1);
                if (r_cnt == tsp_pkg::DIVC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

@@ hdl/task_sample_profiler.sv @@
// Top level of the sampling task profiler: cell chain, dump sequencer and output register.
// Usage: sample and dump items enter on the s_axis channel; tuser is the command
// (0 sample, 1 dump) and tdata holds the task identifier. A sample produces
// nothing. A dump first divides the total by the core count (a core count of 0
// takes the total as the share), then per emitted entry rotates the whole cell chain
// once to find the largest remaining hit counter and runs the percent division
// (skipped when the share is 0); a last rotation finds nothing left and the
// summary item with tlast follows. Results leave through a registered m_axis
// stage; while the receiver stalls the dump holds with the next item ready.
// The input is taken only when the sequencer is idle. The cfg channel writes the
// core count and is always ready. Reset empties the table, clears the counters and
// sets the core count to 2; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module task_sample_profiler #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // task_id[15:0]
    input  wire [tsp_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // command[0]
    input  wire                                 i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // task_ident[15:0], hit_count[47:16], percent[57:48], below_one[58],
    // sample_total[90:59], overflow_count[122:91], zero[127:123]
    output logic [tsp_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // kind[0]
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [tsp_pkg::CORE_W-1:0]           i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW = $clog2(TABLE_DEPTH + 1);

    tsp_pkg::t_state r_state, n_state;
    tsp_pkg::t_cell  w_cell [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_match;
    logic [TABLE_DEPTH-1:0] w_valid;

    logic [tsp_pkg::CORE_W-1:0] r_core;
    logic [UW-1:0]              r_used;
    logic [tsp_pkg::CNT_W-1:0]  r_total;
    logic [tsp_pkg::CNT_W-1:0]  r_lost;
    logic [tsp_pkg::CNT_W-1:0]  r_share;
    logic [IW-1:0]              r_pos;
    logic                       r_found;
    logic [IW-1:0]              r_best;
    logic [tsp_pkg::HITS_W-1:0] r_best_hits;
    logic [tsp_pkg::TID_W-1:0]  r_best_tid;
    logic [tsp_pkg::PCT_W-1:0]  r_pct;

    logic                       r_ovalid;
    logic                       r_o_kind;
    logic [tsp_pkg::TID_W-1:0]  r_o_tid;
    logic [tsp_pkg::HITS_W-1:0] r_o_hits;
    logic [tsp_pkg::PCT_W-1:0]  r_o_pct;
    logic                       r_o_below;
    logic [tsp_pkg::CNT_W-1:0]  r_o_tot;
    logic [tsp_pkg::CNT_W-1:0]  r_o_ovf;
    logic                       r_o_last;

    logic w_in_acc, w_sample, w_dump_start, w_any_match, w_shift, w_set_done;
    logic w_out_free, w_load_entry, w_load_sum, w_head_ok;
    logic w_div_start, w_div_done;
    logic [tsp_pkg::DIV_W-1:0] w_div_a, w_div_b, w_quo;

    assign o_s_axis_tready = (r_state == tsp_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sample        = w_in_acc && (i_s_axis_tuser == tsp_pkg::CMD_SAMPLE);
    assign w_dump_start    = w_in_acc && (i_s_axis_tuser == tsp_pkg::CMD_DUMP);
    assign w_any_match     = |(w_match & w_valid);
    assign w_out_free      = !r_ovalid || i_m_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            assign w_valid[gi] = (UW'(gi) < r_used);
            tsp_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (w_shift),
                .i_shift_in (w_cell[(gi + 1) % TABLE_DEPTH]),
                .i_wr       (w_sample && !w_any_match && (r_used == UW'(gi))),
                .i_inc      (w_sample && w_match[gi] && w_valid[gi]),
                .i_tid      (i_s_axis_tdata),
                .i_clr_done (w_dump_start),
                .i_set_done (w_set_done && (r_best == IW'(gi))),
                .o_cell     (w_cell[gi]),
                .o_match    (w_match[gi])
            );
        end
    endgenerate

    assign w_head_ok = (UW'(r_pos) < r_used) && !w_cell[0].done && (w_cell[0].hits != '0)
                       && (!r_found || (w_cell[0].hits > r_best_hits));

    tsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state      = r_state;
        w_shift      = 1'b0;
        w_set_done   = 1'b0;
        w_div_start  = 1'b0;
        w_div_a      = {{(tsp_pkg::DIV_W-tsp_pkg::CNT_W){1'b0}}, r_total};
        w_div_b      = {{(tsp_pkg::DIV_W-tsp_pkg::CORE_W){1'b0}}, r_core};
        w_load_entry = 1'b0;
        w_load_sum   = 1'b0;
        unique case (r_state)
            tsp_pkg::ST_IDLE: begin
                if (w_dump_start) begin
                    if (r_core == '0) begin
                        n_state = tsp_pkg::ST_SCAN;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = tsp_pkg::ST_PCDIV;
                    end
                end
            end
            tsp_pkg::ST_PCDIV: begin
                if (w_div_done) begin
                    n_state = tsp_pkg::ST_SCAN;
                end
            end
            tsp_pkg::ST_SCAN: begin
                w_shift = 1'b1;
                if (r_pos == IW'(TABLE_DEPTH - 1)) begin
                    n_state = tsp_pkg::ST_PICK;
                end
            end
            tsp_pkg::ST_PICK: begin
                if (!r_found) begin
                    n_state = tsp_pkg::ST_SUM;
                end else begin
                    w_set_done = 1'b1;
                    if (r_share == '0) begin
                        n_state = tsp_pkg::ST_EMIT;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_a     = tsp_pkg::DIV_W'(r_best_hits)
                                      * tsp_pkg::DIV_W'(tsp_pkg::PCT_SCALE);
                        w_div_b     = {{(tsp_pkg::DIV_W-tsp_pkg::CNT_W){1'b0}}, r_share};
                        n_state     = tsp_pkg::ST_PCTDIV;
                    end
                end
            end
            tsp_pkg::ST_PCTDIV: begin
                if (w_div_done) begin
                    n_state = tsp_pkg::ST_EMIT;
                end
            end
            tsp_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_load_entry = 1'b1;
                    n_state      = tsp_pkg::ST_SCAN;
                end
            end
            tsp_pkg::ST_SUM: begin
                if (w_out_free) begin
                    w_load_sum = 1'b1;
                    n_state    = tsp_pkg::ST_IDLE;
                end
            end
            default: n_state = tsp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core  <= tsp_pkg::CORE_RESET;
            r_used  <= '0;
            r_total <= '0;
            r_lost  <= '0;
            r_pos   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_core <= i_cfg_data;
            end
            if (w_sample) begin
                r_total <= r_total + tsp_pkg::CNT_W'(1);
                if (!w_any_match) begin
                    if (r_used < UW'(TABLE_DEPTH)) begin
                        r_used <= r_used + UW'(1);
                    end else begin
                        r_lost <= r_lost + tsp_pkg::CNT_W'(1);
                    end
                end
            end
            if (w_load_sum) begin
                r_used  <= '0;
                r_total <= '0;
                r_lost  <= '0;
            end
            if (w_dump_start || w_load_entry) begin
                r_pos   <= '0;
                r_found <= 1'b0;
            end else if (w_shift) begin
                r_pos <= (r_pos == IW'(TABLE_DEPTH - 1)) ? '0 : r_pos + IW'(1);
                if (w_head_ok) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dump_start && (r_core == '0)) begin
            r_share <= r_total;
        end else if ((r_state == tsp_pkg::ST_PCDIV) && w_div_done) begin
            r_share <= w_quo[tsp_pkg::CNT_W-1:0];
        end
        if (w_shift && w_head_ok) begin
            r_best      <= r_pos;
            r_best_hits <= w_cell[0].hits;
            r_best_tid  <= w_cell[0].tid;
        end
        if (w_set_done && (r_share == '0)) begin
            r_pct <= '0;
        end else if ((r_state == tsp_pkg::ST_PCTDIV) && w_div_done) begin
            r_pct <= (w_quo > tsp_pkg::DIV_W'(tsp_pkg::PCT_MAX)) ? tsp_pkg::PCT_MAX
                                                                : w_quo[tsp_pkg::PCT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_entry || w_load_sum) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_entry) begin
            r_o_kind  <= tsp_pkg::KIND_ENTRY;
            r_o_tid   <= r_best_tid;
            r_o_hits  <= r_best_hits;
            r_o_pct   <= r_pct;
            r_o_below <= (r_pct == '0);
            r_o_tot   <= '0;
            r_o_ovf   <= '0;
            r_o_last  <= 1'b0;
        end else if (w_load_sum) begin
            r_o_kind  <= tsp_pkg::KIND_SUMMARY;
            r_o_tid   <= '0;
            r_o_hits  <= '0;
            r_o_pct   <= '0;
            r_o_below <= 1'b0;
            r_o_tot   <= r_total;
            r_o_ovf   <= r_lost;
            r_o_last  <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'b0, r_o_ovf, r_o_tot, r_o_below, r_o_pct, r_o_hits, r_o_tid};
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

endmodule
`default_nettype wire

@@ hdl/tsp_checker.sv @@
// Port-level checks of the sampling task profiler and their binding.
`timescale 1ns / 1ps
`default_nettype none
module tsp_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_m_axis_tvalid,
    input wire         i_m_axis_tready,
    input wire [127:0] o_m_axis_tdata,
    input wire         o_m_axis_tuser,
    input wire         o_m_axis_tlast,
    input wire         i_s_axis_tvalid,
    input wire         o_s_axis_tready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Stalled output item changed.");

    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == o_m_axis_tuser))
        else $error("Only the summary item may carry tlast.");

    a_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            (o_m_axis_tdata[58] == (o_m_axis_tdata[57:48] == 10'd0)) &&
            (o_m_axis_tdata[47:16] != 32'd0))
        else $error("Entry item has inconsistent hits or below-one flag.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && o_m_axis_tvalid && o_m_axis_tlast
            && i_m_axis_tready |=> !(o_m_axis_tvalid && o_m_axis_tlast))
        else $error("Summary item repeated.");

endmodule

bind task_sample_profiler tsp_checker u_tsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready)
);
`default_nettype wire
